/* rtl/isf_pkg.sv */
// ----------------------------------------------------------------------------
// isf_pkg
// Shared types, constants and byte-match helpers of the ingress source
// anti-spoof filter.
// ----------------------------------------------------------------------------
package isf_pkg;

  localparam int unsigned POS_W  = 6;
  localparam int unsigned MAC_W  = 48;
  localparam int unsigned IP_W   = 32;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 48;

  localparam logic [POS_W-1:0] POS_MAX = 6'd63;

  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
  localparam logic [15:0] ETYPE_ARP  = 16'h0806;

  // byte positions of the checked fields
  localparam logic [POS_W-1:0] POS_SMAC_LO = 6'd6;
  localparam logic [POS_W-1:0] POS_SMAC_HI = 6'd11;
  localparam logic [POS_W-1:0] POS_ETYPE_0 = 6'd12;
  localparam logic [POS_W-1:0] POS_ETYPE_1 = 6'd13;
  localparam logic [POS_W-1:0] POS_ARP_LO  = 6'd14;
  localparam logic [POS_W-1:0] POS_ARP_HI  = 6'd21;
  localparam logic [POS_W-1:0] POS_SHA_LO  = 6'd22;
  localparam logic [POS_W-1:0] POS_SHA_HI  = 6'd27;
  localparam logic [POS_W-1:0] POS_IPSRC_LO = 6'd26;
  localparam logic [POS_W-1:0] POS_IPSRC_HI = 6'd29;
  localparam logic [POS_W-1:0] POS_SPA_LO  = 6'd28;
  localparam logic [POS_W-1:0] POS_SPA_HI  = 6'd31;

  // smallest last-byte positions of frames long enough for each check
  localparam logic [POS_W-1:0] POS_MIN_ETH  = 6'd13;
  localparam logic [POS_W-1:0] POS_MIN_IPV4 = 6'd33;
  localparam logic [POS_W-1:0] POS_MIN_ARP  = 6'd31;

  localparam logic [7:0] ARP_HLEN  = 8'd6;
  localparam logic [7:0] ARP_PLEN  = 8'd4;
  localparam logic [7:0] ARP_OP_REQ = 8'd1;
  localparam logic [7:0] ARP_OP_REP = 8'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENTRY_PRESENT = 2'd0,
    REG_ALLOWED_MAC   = 2'd1,
    REG_ALLOWED_IP    = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    RSN_PASS      = 3'd0,
    RSN_NO_ENTRY  = 3'd1,
    RSN_RUNT      = 3'd2,
    RSN_MAC       = 3'd3,
    RSN_IP        = 3'd4,
    RSN_ARP_BAD   = 3'd5,
    RSN_ARP_ADDR  = 3'd6,
    RSN_ETYPE     = 3'd7
  } reason_t;

  typedef struct packed {
    logic              entry_present;
    logic [MAC_W-1:0]  allowed_mac;
    logic [IP_W-1:0]   allowed_ip;
  } cfg_t;

  typedef struct packed {
    logic              fire;
    logic [7:0]        data;
    logic              last;
  } beat_t;

  typedef struct packed {
    logic              verdict;
    reason_t           reason;
  } result_t;

  // MAC byte in wire order, index 0 is the first byte on the wire
  function automatic logic [7:0] mac_byte(input logic [MAC_W-1:0] mac,
                                          input logic [2:0] idx);
    logic [7:0] r;
    case (idx)
      3'd0:    r = mac[47:40];
      3'd1:    r = mac[39:32];
      3'd2:    r = mac[31:24];
      3'd3:    r = mac[23:16];
      3'd4:    r = mac[15:8];
      default: r = mac[7:0];
    endcase
    return r;
  endfunction

  function automatic logic [7:0] ip_byte(input logic [IP_W-1:0] ip,
                                         input logic [1:0] idx);
    return ip[{idx, 3'b000} +: 8];
  endfunction

  // fixed ARP header bytes: Ethernet/IPv4, hlen 6, plen 4, op request/reply
  function automatic logic arp_byte_bad(input logic [POS_W-1:0] pos,
                                        input logic [7:0] b);
    logic bad;
    case (pos)
      6'd14:   bad = (b != 8'h00);
      6'd15:   bad = (b != 8'h01);
      6'd16:   bad = (b != ETYPE_IPV4[15:8]);
      6'd17:   bad = (b != ETYPE_IPV4[7:0]);
      6'd18:   bad = (b != ARP_HLEN);
      6'd19:   bad = (b != ARP_PLEN);
      6'd20:   bad = (b != 8'h00);
      6'd21:   bad = (b != ARP_OP_REQ) && (b != ARP_OP_REP);
      default: bad = 1'b0;
    endcase
    return bad;
  endfunction

endpackage

/* rtl/isf_parser.sv */
// ----------------------------------------------------------------------------
// isf_parser
// Per-frame byte tracker: match flags, ethertype and byte position, plus the
// verdict for the byte being consumed.
// ----------------------------------------------------------------------------
module isf_parser (
  input  logic              clk,
  input  logic              rst,
  input  isf_pkg::beat_t    beat,
  input  isf_pkg::cfg_t     cfg,
  output isf_pkg::result_t  result
);

  logic [isf_pkg::POS_W-1:0] byte_position;
  logic                      source_mac_match;
  logic [15:0]               ether_type;
  logic                      arp_header_ok;
  logic                      sender_mac_match;
  logic                      source_ip_match;

  logic                      source_mac_match_next;
  logic [15:0]               ether_type_next;
  logic                      arp_header_ok_next;
  logic                      sender_mac_match_next;
  logic                      source_ip_match_next;

  logic [isf_pkg::POS_W-1:0] p;
  logic [7:0]                b;
  logic [isf_pkg::POS_W-1:0] smac_off;
  logic [isf_pkg::POS_W-1:0] sha_off;
  logic [isf_pkg::POS_W-1:0] ipsrc_off;
  logic [isf_pkg::POS_W-1:0] spa_off;
  logic                      in_smac;
  logic                      in_sha;
  logic                      in_ip;
  logic [7:0]                ip_exp;
  isf_pkg::reason_t          reason;

  assign p = byte_position;
  assign b = beat.data;

  assign smac_off  = p - isf_pkg::POS_SMAC_LO;
  assign sha_off   = p - isf_pkg::POS_SHA_LO;
  assign ipsrc_off = p - isf_pkg::POS_IPSRC_LO;
  assign spa_off   = p - isf_pkg::POS_SPA_LO;

  assign in_smac = (p >= isf_pkg::POS_SMAC_LO) && (p <= isf_pkg::POS_SMAC_HI);
  assign in_sha  = (p >= isf_pkg::POS_SHA_LO) && (p <= isf_pkg::POS_SHA_HI);

  always_comb begin
    source_mac_match_next = source_mac_match &
        !(in_smac && (b != isf_pkg::mac_byte(cfg.allowed_mac, smac_off[2:0])));

    if (p == isf_pkg::POS_ETYPE_0 || p == isf_pkg::POS_ETYPE_1) begin
      ether_type_next = {ether_type[7:0], b};
    end else begin
      ether_type_next = ether_type;
    end

    arp_header_ok_next = arp_header_ok & !isf_pkg::arp_byte_bad(p, b);

    sender_mac_match_next = sender_mac_match &
        !(in_sha && (b != isf_pkg::mac_byte(cfg.allowed_mac, sha_off[2:0])));

    // IPv4 source sits at 26..29, ARP sender address at 28..31
    if (ether_type_next == isf_pkg::ETYPE_IPV4) begin
      in_ip  = (p >= isf_pkg::POS_IPSRC_LO) && (p <= isf_pkg::POS_IPSRC_HI);
      ip_exp = isf_pkg::ip_byte(cfg.allowed_ip, ipsrc_off[1:0]);
    end else begin
      in_ip  = (p >= isf_pkg::POS_SPA_LO) && (p <= isf_pkg::POS_SPA_HI);
      ip_exp = isf_pkg::ip_byte(cfg.allowed_ip, spa_off[1:0]);
    end
    source_ip_match_next = source_ip_match & !(in_ip && (b != ip_exp));
  end

  always_comb begin
    if (!cfg.entry_present) begin
      reason = isf_pkg::RSN_NO_ENTRY;
    end else if (p < isf_pkg::POS_MIN_ETH) begin
      reason = isf_pkg::RSN_RUNT;
    end else if (!source_mac_match_next) begin
      reason = isf_pkg::RSN_MAC;
    end else if (ether_type_next == isf_pkg::ETYPE_IPV4) begin
      if (p < isf_pkg::POS_MIN_IPV4) begin
        reason = isf_pkg::RSN_RUNT;
      end else if (!source_ip_match_next) begin
        reason = isf_pkg::RSN_IP;
      end else begin
        reason = isf_pkg::RSN_PASS;
      end
    end else if (ether_type_next == isf_pkg::ETYPE_ARP) begin
      if (p < isf_pkg::POS_MIN_ARP) begin
        reason = isf_pkg::RSN_RUNT;
      end else if (!arp_header_ok_next) begin
        reason = isf_pkg::RSN_ARP_BAD;
      end else if (!sender_mac_match_next || !source_ip_match_next) begin
        reason = isf_pkg::RSN_ARP_ADDR;
      end else begin
        reason = isf_pkg::RSN_PASS;
      end
    end else begin
      reason = isf_pkg::RSN_ETYPE;
    end
  end

  assign result.verdict = (reason == isf_pkg::RSN_PASS);
  assign result.reason  = reason;

  always_ff @(posedge clk) begin
    if (rst || (beat.fire && beat.last)) begin
      byte_position    <= '0;
      source_mac_match <= 1'b1;
      ether_type       <= '0;
      arp_header_ok    <= 1'b1;
      sender_mac_match <= 1'b1;
      source_ip_match  <= 1'b1;
    end else if (beat.fire) begin
      if (byte_position != isf_pkg::POS_MAX) begin
        byte_position <= byte_position + 1'b1;
      end
      source_mac_match <= source_mac_match_next;
      ether_type       <= ether_type_next;
      arp_header_ok    <= arp_header_ok_next;
      sender_mac_match <= sender_mac_match_next;
      source_ip_match  <= source_ip_match_next;
    end
  end

endmodule

/* rtl/ingress_source_spoof_filter.sv */
// ----------------------------------------------------------------------------
// ingress_source_spoof_filter
// Source anti-spoof filter for Ethernet frames carrying IPv4 or ARP.
// ----------------------------------------------------------------------------
// Frames enter one byte per beat starting at the destination MAC; the beat
// with last_byte set yields one verdict/drop_reason beat, other beats yield
// nothing. The filter takes one byte every cycle while frame_stall is low:
// each byte passes an input register, then one compare-and-update step
// against the frame state into the result register, so a verdict is valid
// in the cycle after its last byte leaves the input register. frame_stall rises
// only while a finished verdict is held in the result register and the next
// last byte is waiting behind it. Registers are written through the cfg port
// (always ready) and should be changed between frames.
module ingress_source_spoof_filter (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            frame_valid,
  output logic                            frame_stall,
  input  logic [7:0]                      frame_byte,
  input  logic                            last_byte,
  output logic                            verdict_valid,
  input  logic                            verdict_stall,
  output logic                            verdict,
  output logic [2:0]                      drop_reason,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [isf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [isf_pkg::CFG_DATA_W-1:0]  cfg_data
);

  isf_pkg::cfg_t     cfg;
  isf_pkg::beat_t    beat;
  isf_pkg::result_t  result;

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_last;
  logic       out_free;
  logic       s1_fire;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        isf_pkg::REG_ENTRY_PRESENT: cfg.entry_present <= cfg_data[0];
        isf_pkg::REG_ALLOWED_MAC:   cfg.allowed_mac   <= cfg_data[isf_pkg::MAC_W-1:0];
        isf_pkg::REG_ALLOWED_IP:    cfg.allowed_ip    <= cfg_data[isf_pkg::IP_W-1:0];
        default: ;
      endcase
    end
  end

  // non-last bytes only touch frame state, so they never wait on the output
  assign out_free    = !verdict_valid || !verdict_stall;
  assign s1_fire     = s1_valid && (!s1_last || out_free);
  assign frame_stall = s1_valid && !s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!frame_stall) begin
      s1_valid <= frame_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_valid && !frame_stall) begin
      s1_byte <= frame_byte;
      s1_last <= last_byte;
    end
  end

  assign beat.fire = s1_fire;
  assign beat.data = s1_byte;
  assign beat.last = s1_last;

  isf_parser u_parser (
    .clk    (clk),
    .rst    (rst),
    .beat   (beat),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      verdict_valid <= 1'b0;
    end else if (s1_fire && s1_last) begin
      verdict_valid <= 1'b1;
    end else if (!verdict_stall) begin
      verdict_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_last) begin
      verdict     <= result.verdict;
      drop_reason <= result.reason;
    end
  end

endmodule

/* rtl/isf_checker.sv */
// ----------------------------------------------------------------------------
// isf_checker
// Port-level checks of the ingress source anti-spoof filter, bound to the
// top level.
// ----------------------------------------------------------------------------
module isf_checker (
  input logic       clk,
  input logic       rst,
  input logic       frame_stall,
  input logic       verdict_valid,
  input logic       verdict_stall,
  input logic       verdict,
  input logic [2:0] drop_reason
);

  // a held verdict beat keeps its value
  a_verdict_hold: assert property (@(posedge clk) disable iff (rst)
      verdict_valid && verdict_stall |=>
      verdict_valid && $stable(verdict) && $stable(drop_reason))
    else $error("verdict beat changed while stalled");

  a_pass_code: assert property (@(posedge clk) disable iff (rst)
      verdict_valid |->
      (verdict == (drop_reason == isf_pkg::RSN_PASS)))
    else $error("verdict and drop_reason disagree");

  // input backpressure only comes from a full, stalled result register
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
      frame_stall |-> verdict_valid && verdict_stall)
    else $error("frame_stall without a blocked verdict");

  a_reset_empty: assert property (@(posedge clk)
      rst |=> !verdict_valid && !frame_stall)
    else $error("output not empty after reset");

endmodule

bind ingress_source_spoof_filter isf_checker u_isf_checker (
  .clk           (clk),
  .rst           (rst),
  .frame_stall   (frame_stall),
  .verdict_valid (verdict_valid),
  .verdict_stall (verdict_stall),
  .verdict       (verdict),
  .drop_reason   (drop_reason)
);

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives Ethernet frames byte by byte into the ingress source spoof filter.
// A scoreboard tracks the frame state and configuration and predicts each
// verdict and drop reason. Directed frames cover every drop reason and the
// extreme lengths. Random frames follow, mostly well-formed IPv4 and ARP,
// under several configurations. Both sides idle at random, and one long
// receiver hold backs the filter up.
// ----------------------------------------------------------------------------
module testbench;

  localparam int IDLE_LIMIT       = 2000;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES     = 8;
  localparam int MAX_WAIT         = 18;
  localparam int PHASES           = 6;
  localparam int FRAMES_PER_PHASE = 2;

  // index past the register list, writes to it must be ignored
  localparam logic [isf_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef enum int {FR_IPV4, FR_ARP, FR_OTHER, FR_RUNT, FR_NOISE} frame_kind_t;

  class verdict_scoreboard;
    logic                      entry_en;
    logic [isf_pkg::MAC_W-1:0] mac;
    logic [isf_pkg::IP_W-1:0]  ip;
    logic [isf_pkg::POS_W-1:0] pos;
    logic [15:0]               etype;
    logic                      smac_ok, arp_ok, sha_ok, sip_ok;
    isf_pkg::result_t          expected_q[$];
    int                        errors;

    function new();
      entry_en = 1'b0;
      mac      = '0;
      ip       = '0;
      errors   = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      pos     = '0;
      etype   = '0;
      smac_ok = 1'b1;
      arp_ok  = 1'b1;
      sha_ok  = 1'b1;
      sip_ok  = 1'b1;
    endfunction

    function logic [7:0] mac_at(int i);
      return mac[8*(5-i) +: 8];
    endfunction

    function logic [7:0] ip_at(int i);
      return ip[8*i +: 8];
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void write_reg(logic [isf_pkg::CFG_IDX_W-1:0] idx,
                            logic [isf_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        isf_pkg::REG_ENTRY_PRESENT: entry_en = data[0];
        isf_pkg::REG_ALLOWED_MAC:   mac = data[isf_pkg::MAC_W-1:0];
        isf_pkg::REG_ALLOWED_IP:    ip = data[isf_pkg::IP_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_byte(logic [7:0] b, logic last);
      int               p;
      int               len;
      isf_pkg::reason_t rsn;
      isf_pkg::result_t res;
      p = pos;
      if (p >= 6 && p <= 11 && b != mac_at(p - 6)) smac_ok = 1'b0;
      if (p == 12 || p == 13) etype = {etype[7:0], b};
      // fixed ARP header: hrd 1, pro IPv4, hlen 6, plen 4, op request/reply
      case (p)
        14, 20: if (b != 8'h00) arp_ok = 1'b0;
        15: if (b != 8'h01) arp_ok = 1'b0;
        16: if (b != isf_pkg::ETYPE_IPV4[15:8]) arp_ok = 1'b0;
        17: if (b != isf_pkg::ETYPE_IPV4[7:0]) arp_ok = 1'b0;
        18: if (b != isf_pkg::ARP_HLEN) arp_ok = 1'b0;
        19: if (b != isf_pkg::ARP_PLEN) arp_ok = 1'b0;
        21: if (b != isf_pkg::ARP_OP_REQ && b != isf_pkg::ARP_OP_REP) arp_ok = 1'b0;
        default: ;
      endcase
      if (p >= 22 && p <= 27 && b != mac_at(p - 22)) sha_ok = 1'b0;
      if (etype == isf_pkg::ETYPE_IPV4) begin
        if (p >= 26 && p <= 29 && b != ip_at(p - 26)) sip_ok = 1'b0;
      end else if (p >= 28 && p <= 31 && b != ip_at(p - 28)) begin
        sip_ok = 1'b0;
      end
      if (!last) begin
        if (pos != isf_pkg::POS_MAX) pos++;
        return;
      end
      len = p + 1;
      if (!entry_en) rsn = isf_pkg::RSN_NO_ENTRY;
      else if (len < 14) rsn = isf_pkg::RSN_RUNT;
      else if (!smac_ok) rsn = isf_pkg::RSN_MAC;
      else if (etype == isf_pkg::ETYPE_IPV4) begin
        if (len < 34) rsn = isf_pkg::RSN_RUNT;
        else if (!sip_ok) rsn = isf_pkg::RSN_IP;
        else rsn = isf_pkg::RSN_PASS;
      end else if (etype == isf_pkg::ETYPE_ARP) begin
        if (len < 32) rsn = isf_pkg::RSN_RUNT;
        else if (!arp_ok) rsn = isf_pkg::RSN_ARP_BAD;
        else if (!sha_ok || !sip_ok) rsn = isf_pkg::RSN_ARP_ADDR;
        else rsn = isf_pkg::RSN_PASS;
      end else rsn = isf_pkg::RSN_ETYPE;
      res.verdict = (rsn == isf_pkg::RSN_PASS);
      res.reason  = rsn;
      expected_q.push_back(res);
      clear_frame();
    endfunction

    function void check_verdict(logic v, logic [2:0] r);
      isf_pkg::result_t exp_res;
      if (expected_q.size() == 0) begin
        $error("verdict beat with none pending: verdict %0d drop_reason %0d", v, r);
        errors++;
        return;
      end
      exp_res = expected_q.pop_front();
      if (v !== exp_res.verdict) begin
        $error("verdict: expected %0d, actual %0d", exp_res.verdict, v);
        errors++;
      end
      if (r !== exp_res.reason) begin
        $error("drop_reason: expected %0d, actual %0d", exp_res.reason, r);
        errors++;
      end
    endfunction
  endclass

  logic                           clk;
  logic                           rst;
  logic                           frame_valid;
  logic                           frame_stall;
  logic [7:0]                     frame_byte;
  logic                           last_byte;
  logic                           verdict_valid;
  logic                           verdict_stall;
  logic                           verdict;
  logic [2:0]                     drop_reason;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [isf_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [isf_pkg::CFG_DATA_W-1:0] cfg_data;

  verdict_scoreboard sb;
  logic [7:0]        frame_buf[$];
  bit                no_idle;
  bit                long_hold_req;
  int                idle_cycles;

  ingress_source_spoof_filter i_dut (
    .clk           (clk),
    .rst           (rst),
    .frame_valid   (frame_valid),
    .frame_stall   (frame_stall),
    .frame_byte    (frame_byte),
    .last_byte     (last_byte),
    .verdict_valid (verdict_valid),
    .verdict_stall (verdict_stall),
    .verdict       (verdict),
    .drop_reason   (drop_reason),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int draw_wait();
    if (no_idle || $urandom_range(0, 1)) return 0;
    return $urandom_range(0, MAX_WAIT);
  endfunction

  function automatic logic [isf_pkg::CFG_DATA_W-1:0] rand48();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v[isf_pkg::CFG_DATA_W-1:0];
  endfunction

  function automatic void put_byte(int idx, logic [7:0] val);
    if (idx < frame_buf.size()) frame_buf[idx] = val;
  endfunction

  // random bytes, then the fields of the given kind laid over them
  function automatic void build_frame(frame_kind_t kind, int len);
    logic [15:0] et;
    frame_buf.delete();
    for (int i = 0; i < len; i++) frame_buf.push_back(8'($urandom_range(0, 255)));
    if (kind == FR_RUNT || kind == FR_NOISE) return;
    for (int i = 0; i < 6; i++) put_byte(6 + i, sb.mac_at(i));
    case (kind)
      FR_IPV4: et = isf_pkg::ETYPE_IPV4;
      FR_ARP:  et = isf_pkg::ETYPE_ARP;
      default: et = 16'($urandom_range(0, 65535));
    endcase
    put_byte(12, et[15:8]);
    put_byte(13, et[7:0]);
    if (kind == FR_IPV4) begin
      for (int i = 0; i < 4; i++) put_byte(26 + i, sb.ip_at(i));
    end else if (kind == FR_ARP) begin
      put_byte(14, 8'h00);
      put_byte(15, 8'h01);
      put_byte(16, isf_pkg::ETYPE_IPV4[15:8]);
      put_byte(17, isf_pkg::ETYPE_IPV4[7:0]);
      put_byte(18, isf_pkg::ARP_HLEN);
      put_byte(19, isf_pkg::ARP_PLEN);
      put_byte(20, 8'h00);
      put_byte(21, $urandom_range(0, 1) ? isf_pkg::ARP_OP_REQ : isf_pkg::ARP_OP_REP);
      for (int i = 0; i < 6; i++) put_byte(22 + i, sb.mac_at(i));
      for (int i = 0; i < 4; i++) put_byte(28 + i, sb.ip_at(i));
    end
  endfunction

  // leaves valid high; the next beat or the drain lowers it
  task automatic send_byte(logic [7:0] b, logic last);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      frame_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    frame_valid <= 1'b1;
    frame_byte  <= b;
    last_byte   <= last;
    do @(posedge clk); while (frame_stall);
    sb.note_byte(b, last);
    @(negedge clk);
  endtask

  task automatic send_frame();
    foreach (frame_buf[i]) send_byte(frame_buf[i], i == frame_buf.size() - 1);
  endtask

  task automatic send_random_frame(frame_kind_t kind);
    int min_len;
    int len;
    int sel;
    int idx;
    case (kind)
      FR_IPV4: min_len = 34;
      FR_ARP:  min_len = 32;
      default: min_len = 14;
    endcase
    sel = $urandom_range(0, 9);
    if (kind == FR_RUNT) len = $urandom_range(1, 13);
    else if (kind == FR_NOISE) len = $urandom_range(1, 70);
    else if (sel == 0) len = $urandom_range(1, min_len - 1);
    else if (sel == 1) len = $urandom_range(60, 80);
    else len = $urandom_range(min_len, min_len + 10);
    build_frame(kind, len);
    // damage one byte of the checked headers now and then
    if (kind != FR_RUNT && kind != FR_NOISE && len > 6 && $urandom_range(0, 2) == 0) begin
      idx = $urandom_range(6, (len - 1 < 31) ? len - 1 : 31);
      frame_buf[idx] ^= 8'($urandom_range(1, 255));
    end
    send_frame();
  endtask

  function automatic frame_kind_t pick_kind();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return FR_IPV4;
    if (r < 7) return FR_ARP;
    if (r == 7) return FR_OTHER;
    if (r == 8) return FR_RUNT;
    return FR_NOISE;
  endfunction

  task automatic wait_drained();
    frame_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // leaves cfg_valid high so back-to-back writes need one assignment per step
  task automatic write_reg(logic [isf_pkg::CFG_IDX_W-1:0] idx,
                           logic [isf_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    @(negedge clk);
  endtask

  // unused upper data bits carry junk
  task automatic apply_config(logic entry, logic [isf_pkg::MAC_W-1:0] mac,
                              logic [isf_pkg::IP_W-1:0] ip);
    logic [isf_pkg::CFG_DATA_W-1:0] junk;
    junk = rand48();
    write_reg(isf_pkg::REG_ENTRY_PRESENT, {junk[isf_pkg::CFG_DATA_W-1:1], entry});
    write_reg(isf_pkg::REG_ALLOWED_MAC, mac);
    write_reg(isf_pkg::REG_ALLOWED_IP, {junk[isf_pkg::CFG_DATA_W-1:isf_pkg::IP_W], ip});
    write_reg(REG_UNUSED, rand48());
    cfg_valid <= 1'b0;
  endtask

  task automatic run_directed();
    // no entry configured yet
    build_frame(FR_IPV4, 34);
    send_frame();
    build_frame(FR_RUNT, 1);
    send_frame();
    wait_drained();
    apply_config(1'b1, rand48(), $urandom);
    build_frame(FR_IPV4, 34);
    send_frame();
    build_frame(FR_IPV4, 33);
    send_frame();
    build_frame(FR_ARP, 32);
    put_byte(21, isf_pkg::ARP_OP_REQ);
    send_frame();
    build_frame(FR_ARP, 40);
    put_byte(21, isf_pkg::ARP_OP_REP);
    send_frame();
    build_frame(FR_ARP, 31);
    send_frame();
    build_frame(FR_RUNT, 13);
    send_frame();
    build_frame(FR_IPV4, 14);
    send_frame();
    build_frame(FR_OTHER, 14);
    put_byte(12, 8'h86);
    put_byte(13, 8'hdd);
    send_frame();
    build_frame(FR_IPV4, 34);
    frame_buf[9] ^= 8'h01;
    send_frame();
    build_frame(FR_IPV4, 34);
    frame_buf[29] ^= 8'h80;
    send_frame();
    build_frame(FR_ARP, 32);
    put_byte(18, isf_pkg::ARP_HLEN + 8'd1);
    send_frame();
    build_frame(FR_ARP, 32);
    put_byte(21, isf_pkg::ARP_OP_REP + 8'd1);
    send_frame();
    build_frame(FR_ARP, 32);
    frame_buf[27] ^= 8'h01;
    send_frame();
    build_frame(FR_ARP, 32);
    frame_buf[28] ^= 8'h01;
    send_frame();
    // past the saturating byte counter
    build_frame(FR_IPV4, 100);
    send_frame();
    build_frame(FR_NOISE, 20);
    foreach (frame_buf[i]) frame_buf[i] = 8'hff;
    send_frame();
    build_frame(FR_NOISE, 20);
    foreach (frame_buf[i]) frame_buf[i] = 8'h00;
    send_frame();
  endtask

  // result side: random stall per beat, one long hold on request
  initial begin : verdict_sink
    int hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold = LONG_HOLD_CYCLES;
      end
      verdict_stall <= (hold > 0);
      if (hold > 0) hold--;
      @(posedge clk);
      if (!rst && verdict_valid && !verdict_stall) begin
        sb.check_verdict(verdict, drop_reason);
        hold = draw_wait();
      end
    end
  end

  always @(posedge clk) begin
    if ((frame_valid && !frame_stall) || (verdict_valid && !verdict_stall) ||
        (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    sb            = new();
    clk           = 1'b0;
    rst           = 1'b1;
    frame_valid   = 1'b0;
    frame_byte    = '0;
    last_byte     = 1'b0;
    verdict_stall = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    no_idle       = 1'b0;
    long_hold_req = 1'b0;
    idle_cycles   = 0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    run_directed();
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      case (ph)
        0: apply_config(1'b1, '0, '0);
        1: apply_config(1'b1, '1, '1);
        2: apply_config(1'b0, rand48(), $urandom);
        default: apply_config(1'b1, rand48(), $urandom);
      endcase
      no_idle = (ph == 1 || ph == 3 || ph == 5);
      // back-to-back short frames against a held result port
      if (ph == 3) long_hold_req = 1'b1;
      for (int k = 0; k < FRAMES_PER_PHASE; k++)
        send_random_frame((ph == 3 && k < 4) ? FR_RUNT : pick_kind());
    end
    wait_drained();
    if (sb.errors == 0 && sb.pending() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

/* ingress_source_spoof_filter.f */
rtl/isf_pkg.sv
rtl/isf_parser.sv
rtl/ingress_source_spoof_filter.sv
rtl/isf_checker.sv
tb/testbench.sv
